// ===== rtl/gae_pkg.sv =====
// gae_pkg: shared widths, register indexes and reset values for the
// gradient anchor extraction block. No dependencies.
package gae_pkg;

    localparam int GRAD_W = 11;   // signed sobel derivative
    localparam int MAG_W  = 11;   // gradient magnitude
    localparam int CFG_W  = 11;   // widest configuration register
    localparam int STEP_W = 8;    // grid step and grid phases
    localparam int SZ_W   = 13;   // frame sizes and position compares
    localparam int POS_W  = 10;   // reported anchor row and column
    localparam int IDX_W  = 3;    // configuration register index

    localparam logic [IDX_W-1:0] REG_PROPOSAL_THRESHOLD = 3'd0;
    localparam logic [IDX_W-1:0] REG_ANCHOR_STEP        = 3'd1;
    localparam logic [IDX_W-1:0] REG_ANCHOR_MARGIN      = 3'd2;
    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH        = 3'd3;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT       = 3'd4;

    localparam logic [MAG_W-1:0]  RST_PROPOSAL_THRESHOLD = 11'd36;
    localparam logic [STEP_W-1:0] RST_ANCHOR_STEP        = 8'd1;
    localparam logic [MAG_W-1:0]  RST_ANCHOR_MARGIN      = 11'd8;
    localparam logic [CFG_W-1:0]  RST_FRAME_WIDTH        = 11'd640;
    localparam logic [CFG_W-1:0]  RST_FRAME_HEIGHT       = 11'd480;

endpackage

// ===== rtl/gae_line_store.sv =====
// gae_line_store: line stores for upper and middle row magnitudes and the
// middle row orientation. Uses gae_pkg for the magnitude width.
module gae_line_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [AW-1:0]            rd_addr,
    input  logic [AW-1:0]            rd_addr_right,
    input  logic                     wr_en,
    input  logic [AW-1:0]            wr_addr,
    input  logic [gae_pkg::MAG_W-1:0] wr_upper,
    input  logic [gae_pkg::MAG_W-1:0] wr_mid,
    input  logic                     wr_ori,
    output logic [gae_pkg::MAG_W-1:0] rd_upper,
    output logic [gae_pkg::MAG_W-1:0] rd_mid,
    output logic [gae_pkg::MAG_W-1:0] rd_right,
    output logic                     rd_ori
);

    logic [gae_pkg::MAG_W-1:0] upper_mem [DEPTH];
    logic [gae_pkg::MAG_W-1:0] mid_mem   [DEPTH];
    logic                      ori_mem   [DEPTH];

    logic [gae_pkg::MAG_W-1:0] rd_upper_reg;
    logic [gae_pkg::MAG_W-1:0] rd_mid_reg;
    logic [gae_pkg::MAG_W-1:0] rd_right_reg;
    logic                      rd_ori_reg;

    // read-first: a read at the written address returns the old entry
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            upper_mem[wr_addr] <= wr_upper;
            mid_mem[wr_addr]   <= wr_mid;
            ori_mem[wr_addr]   <= wr_ori;
        end
        if (rd_en) begin
            rd_upper_reg <= upper_mem[rd_addr];
            rd_mid_reg   <= mid_mem[rd_addr];
            rd_right_reg <= mid_mem[rd_addr_right];
            rd_ori_reg   <= ori_mem[rd_addr];
        end
    end

    assign rd_upper = rd_upper_reg;
    assign rd_mid   = rd_mid_reg;
    assign rd_right = rd_right_reg;
    assign rd_ori   = rd_ori_reg;

endmodule

// ===== rtl/gae_scan_ctrl.sv =====
// gae_scan_ctrl: raster position counters and anchor grid phases.
// Uses gae_pkg for widths.
module gae_scan_ctrl #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int AW         = 10,
    parameter int RW         = 10
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       advance,
    input  logic                       frame_start,
    input  logic [gae_pkg::CFG_W-1:0]  frame_width,
    input  logic [gae_pkg::CFG_W-1:0]  frame_height,
    input  logic [gae_pkg::STEP_W-1:0] anchor_step,
    output logic [AW-1:0]              col,
    output logic [RW-1:0]              row,
    output logic                       on_grid
);

    localparam int SZ_W   = gae_pkg::SZ_W;
    localparam int STEP_W = gae_pkg::STEP_W;

    logic [AW-1:0]     col_reg, col_next, col_cur;
    logic [RW-1:0]     row_reg, row_next, row_cur;
    logic [STEP_W-1:0] cph_reg, cph_next, cph_cur;
    logic [STEP_W-1:0] rph_reg, rph_next, rph_cur;
    logic [STEP_W-1:0] step_eff;
    logic [SZ_W-1:0]   width_eff, height_eff, col_ext, row_ext, row_inc;
    logic              last_col;

    function automatic logic [SZ_W-1:0] clamp_size(input logic [gae_pkg::CFG_W-1:0] v,
                                                   input logic [SZ_W-1:0] hi);
        logic [SZ_W-1:0] ve;
        ve = SZ_W'(v);
        if (ve < SZ_W'(3)) begin
            return SZ_W'(3);
        end else if (ve > hi) begin
            return hi;
        end
        return ve;
    endfunction

    function automatic logic [STEP_W-1:0] phase_inc(input logic [STEP_W-1:0] p,
                                                   input logic [STEP_W-1:0] step);
        logic [STEP_W:0] p1;
        p1 = {1'b0, p} + (STEP_W+1)'(1);
        return (p1 >= {1'b0, step}) ? '0 : p1[STEP_W-1:0];
    endfunction

    always_comb begin
        step_eff   = (anchor_step == '0) ? STEP_W'(1) : anchor_step;
        width_eff  = clamp_size(frame_width, SZ_W'(MAX_WIDTH));
        height_eff = clamp_size(frame_height, SZ_W'(MAX_HEIGHT));

        col_cur = frame_start ? '0 : col_reg;
        row_cur = frame_start ? '0 : row_reg;
        cph_cur = frame_start ? '0 : cph_reg;
        rph_cur = frame_start ? '0 : rph_reg;

        col_ext  = SZ_W'(col_cur);
        row_ext  = SZ_W'(row_cur);
        row_inc  = row_ext + SZ_W'(1);
        last_col = (col_ext + SZ_W'(1)) >= width_eff;

        if (last_col) begin
            col_next = '0;
            cph_next = '0;
            row_next = (row_inc >= height_eff) ? '0 : RW'(row_inc);
            rph_next = (row_next == RW'(2)) ? '0 : phase_inc(rph_cur, step_eff);
        end else begin
            col_next = AW'(col_ext + SZ_W'(1));
            cph_next = (col_next == AW'(1)) ? '0 : phase_inc(cph_cur, step_eff);
            row_next = row_cur;
            rph_next = rph_cur;
        end

        // decided pixel sits one row up and must keep a one-pixel border
        on_grid = (row_ext >= SZ_W'(2)) && (row_inc <= height_eff) &&
                  (col_ext >= SZ_W'(1)) && ((col_ext + SZ_W'(2)) <= width_eff) &&
                  (rph_cur == '0) && (cph_cur == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            cph_reg <= '0;
            rph_reg <= '0;
        end else if (advance) begin
            col_reg <= col_next;
            row_reg <= row_next;
            cph_reg <= cph_next;
            rph_reg <= rph_next;
        end
    end

    assign col = col_cur;
    assign row = row_cur;

endmodule

// ===== rtl/gradient_anchor_extraction_top.sv =====
// gradient_anchor_extraction_top: top level of the gradient anchor extractor.
// Uses gae_pkg, gae_scan_ctrl and gae_line_store.
//
// One gradient pair enters per clock while the output is not stalled, and one
// result beat leaves per input beat via the stage 1 and output registers. Each
// pixel does one read-modify-write of the column entry in the line stores (read
// at accept, write as it leaves stage 1); a pixel that hits the column still
// being written by the pixel ahead of it takes the pending data from a bypass
// register, so the rate stays one pixel per clock. The right neighbour comes
// from a second read port of the middle row store, the left neighbour from the
// previous pixel. The line stores need no clearing after reset; entries read
// during the first two rows of a frame never feed an anchor decision.
module gradient_anchor_extraction_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [gae_pkg::IDX_W-1:0]   cfg_index,
    input  logic [gae_pkg::CFG_W-1:0]   cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [gae_pkg::GRAD_W-1:0] s_grad_x,
    input  logic signed [gae_pkg::GRAD_W-1:0] s_grad_y,
    input  logic                        s_frame_start,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [gae_pkg::MAG_W-1:0]   m_magnitude,
    output logic                        m_vertical_edge,
    output logic                        m_anchor_found,
    output logic [gae_pkg::POS_W-1:0]   m_anchor_row,
    output logic [gae_pkg::POS_W-1:0]   m_anchor_col
);

    localparam int AW     = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_HEIGHT);
    localparam int MAG_W  = gae_pkg::MAG_W;
    localparam int GRAD_W = gae_pkg::GRAD_W;
    localparam int POS_W  = gae_pkg::POS_W;

    // configuration
    logic [MAG_W-1:0]           proposal_threshold_reg;
    logic [gae_pkg::STEP_W-1:0] anchor_step_reg;
    logic [MAG_W-1:0]           anchor_margin_reg;
    logic [gae_pkg::CFG_W-1:0]  frame_width_reg;
    logic [gae_pkg::CFG_W-1:0]  frame_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            proposal_threshold_reg <= gae_pkg::RST_PROPOSAL_THRESHOLD;
            anchor_step_reg        <= gae_pkg::RST_ANCHOR_STEP;
            anchor_margin_reg      <= gae_pkg::RST_ANCHOR_MARGIN;
            frame_width_reg        <= gae_pkg::RST_FRAME_WIDTH;
            frame_height_reg       <= gae_pkg::RST_FRAME_HEIGHT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                gae_pkg::REG_PROPOSAL_THRESHOLD: proposal_threshold_reg <= cfg_wr_data;
                gae_pkg::REG_ANCHOR_STEP: anchor_step_reg <= cfg_wr_data[gae_pkg::STEP_W-1:0];
                gae_pkg::REG_ANCHOR_MARGIN: anchor_margin_reg <= cfg_wr_data;
                gae_pkg::REG_FRAME_WIDTH: frame_width_reg <= cfg_wr_data;
                gae_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    function automatic logic [MAG_W-1:0] abs_grad(input logic [GRAD_W-1:0] g);
        logic [GRAD_W-1:0] n;
        n = ~g + GRAD_W'(1);
        return g[GRAD_W-1] ? MAG_W'(n) : MAG_W'(g);
    endfunction

    // pipeline control
    logic accept, st1_adv;
    logic st1_valid_reg, m_valid_reg;

    assign st1_adv = st1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !st1_valid_reg || st1_adv;
    assign accept  = s_valid && s_ready;

    // accept stage: position, magnitude, line store read
    logic [AW-1:0]    s_col, s_col_right;
    logic [RW-1:0]    s_row;
    logic             s_on_grid;
    logic [MAG_W-1:0] s_dx, s_dy, s_mag;
    logic [MAG_W:0]   s_sum;
    logic             s_vert, s_fwd_hit;

    gae_scan_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AW         (AW),
        .RW         (RW)
    ) u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (accept),
        .frame_start  (s_frame_start),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .anchor_step  (anchor_step_reg),
        .col          (s_col),
        .row          (s_row),
        .on_grid      (s_on_grid)
    );

    // stage 1 registers
    logic [MAG_W-1:0] st1_mag_reg;
    logic             st1_vert_reg;
    logic [AW-1:0]    st1_col_reg;
    logic [RW-1:0]    st1_row_reg;
    logic             st1_on_grid_reg;
    logic             fwd_hit_reg;
    logic [MAG_W-1:0] fwd_upper_reg, fwd_mid_reg;
    logic             fwd_ori_reg;
    logic [MAG_W-1:0] prev_mid_reg;

    logic [MAG_W-1:0] rd_upper, rd_mid, rd_right;
    logic             rd_ori;
    logic [MAG_W-1:0] up, mid;
    logic             ori;

    always_comb begin
        s_dx   = abs_grad(s_grad_x);
        s_dy   = abs_grad(s_grad_y);
        s_sum  = {1'b0, s_dx} + {1'b0, s_dy};
        s_mag  = s_sum[MAG_W] ? '1 : s_sum[MAG_W-1:0];
        s_vert = s_dx > s_dy;
        // right neighbour only matters off the border, so the wrap is harmless
        s_col_right = (s_col == AW'(MAX_WIDTH - 1)) ? '0 : s_col + AW'(1);
        // the pixel ahead writes its column on this same edge
        s_fwd_hit = st1_adv && (st1_col_reg == s_col);
    end

    gae_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_store (
        .aclk          (aclk),
        .rd_en         (accept),
        .rd_addr       (s_col),
        .rd_addr_right (s_col_right),
        .wr_en         (st1_adv),
        .wr_addr       (st1_col_reg),
        .wr_upper      (mid),
        .wr_mid        (st1_mag_reg),
        .wr_ori        (st1_vert_reg),
        .rd_upper      (rd_upper),
        .rd_mid        (rd_mid),
        .rd_right      (rd_right),
        .rd_ori        (rd_ori)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (accept) begin
            st1_valid_reg <= 1'b1;
        end else if (st1_adv) begin
            st1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_mag_reg     <= s_mag;
            st1_vert_reg    <= s_vert;
            st1_col_reg     <= s_col;
            st1_row_reg     <= s_row;
            st1_on_grid_reg <= s_on_grid;
            fwd_hit_reg     <= s_fwd_hit;
            fwd_upper_reg   <= mid;
            fwd_mid_reg     <= st1_mag_reg;
            fwd_ori_reg     <= st1_vert_reg;
        end
        if (st1_adv) begin
            prev_mid_reg <= mid;
        end
    end

    // stage 1: anchor decision on the middle row pixel
    logic [MAG_W:0] need_up, need_down, need_left, need_right;
    logic           cross_ok, st1_anchor;
    logic [RW-1:0]  st1_anchor_row;

    always_comb begin
        up  = fwd_hit_reg ? fwd_upper_reg : rd_upper;
        mid = fwd_hit_reg ? fwd_mid_reg : rd_mid;
        ori = fwd_hit_reg ? fwd_ori_reg : rd_ori;

        need_up    = {1'b0, up}           + {1'b0, anchor_margin_reg};
        need_down  = {1'b0, st1_mag_reg}  + {1'b0, anchor_margin_reg};
        need_left  = {1'b0, prev_mid_reg} + {1'b0, anchor_margin_reg};
        need_right = {1'b0, rd_right}     + {1'b0, anchor_margin_reg};

        if (ori) begin
            cross_ok = ({1'b0, mid} >= need_left) && ({1'b0, mid} >= need_right);
        end else begin
            cross_ok = ({1'b0, mid} >= need_up) && ({1'b0, mid} >= need_down);
        end
        st1_anchor = st1_on_grid_reg && (mid >= proposal_threshold_reg) && cross_ok;
        st1_anchor_row = (st1_row_reg == '0) ? '0 : st1_row_reg - RW'(1);
    end

    // output register
    logic [MAG_W-1:0] out_mag_reg;
    logic             out_vert_reg, out_anchor_reg;
    logic [POS_W-1:0] out_row_reg, out_col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (st1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_adv) begin
            out_mag_reg    <= st1_mag_reg;
            out_vert_reg   <= st1_vert_reg;
            out_anchor_reg <= st1_anchor;
            out_row_reg    <= POS_W'(st1_anchor_row);
            out_col_reg    <= POS_W'(st1_col_reg);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_magnitude     = out_mag_reg;
    assign m_vertical_edge = out_vert_reg;
    assign m_anchor_found  = out_anchor_reg;
    assign m_anchor_row    = out_row_reg;
    assign m_anchor_col    = out_col_reg;

    // a stalled output must hold the pixel in stage 1 and block the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        (st1_valid_reg && m_valid_reg && !m_ready) |-> !s_ready)
        else $error("input taken while stage 1 is blocked");

    // a held pixel keeps its column, so the line store write address is stable
    assert property (@(posedge aclk) disable iff (!aresetn)
        (st1_valid_reg && !st1_adv) |=> ($stable(st1_col_reg) && st1_valid_reg))
        else $error("stage 1 pixel lost while stalled");

    // bypass is only armed when the pixel ahead wrote the same column
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_fwd_hit) |=> (fwd_hit_reg && (st1_col_reg == $past(st1_col_reg))))
        else $error("bypass armed for a different column");

    // an anchor never lies on the frame border
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_anchor_reg) |-> ((out_row_reg != '0) && (out_col_reg != '0)))
        else $error("anchor reported on the border");

endmodule
